FILE: rtl/sti_pkg.sv
// Shared constants for the sorted table insert unit.
package sti_pkg;

	// Fixed widths of the key port and of the result count fields.
	localparam int IN_KEY_W = 32;
	localparam int FIELD_W  = 7;

endpackage

FILE: rtl/sti_key_cmp.sv
// Key comparator shared by every search step: unsigned or two's complement less-than.
module sti_key_cmp #(
	parameter int KEY_BITS = 32
) (
	input  logic [KEY_BITS-1:0] key_a,
	input  logic [KEY_BITS-1:0] key_b,
	input  logic                signed_mode,
	output logic                a_less
);

	localparam logic [KEY_BITS-1:0] SIGN_BIT = KEY_BITS'(1) << (KEY_BITS - 1);

	logic [KEY_BITS-1:0] flip;
	logic [KEY_BITS-1:0] a_x;
	logic [KEY_BITS-1:0] b_x;

	// Flipping the sign bit maps two's complement order onto unsigned order.
	assign flip   = signed_mode ? SIGN_BIT : '0;
	assign a_x    = key_a ^ flip;
	assign b_x    = key_b ^ flip;
	assign a_less = (a_x < b_x);

endmodule

FILE: rtl/sorted_table_insert_unit.sv
// Top level of the sorted table insert unit: sequencer, key memory and result registers.
//
//  channel   signals                         direction  handshake
//  --------  ------------------------------  ---------  -----------------------------
//  command   start, new_key / busy           in / out   taken when start && !busy
//  result    done, insert_position,          out        one-cycle strobe, no stall
//            entry_total, table_full
//  config    cfg_valid, cfg_data / cfg_ready in / out   taken when cfg_valid && cfg_ready
//
// A full table answers in the cycle after the key is taken. Otherwise an item runs through S
// binary search steps (S at most log2(count)+1), each a memory read state and then a compare
// state, then moves up the M = count - position entries above its place, the key memory moving
// one entry per cycle and reading two places below the one it writes, and last writes the key.
// Reset clears the count and the mode register; entries at or above the count may be read but
// are never used, so the memory needs no clearing pass. The result strobe cannot be held off.
module sorted_table_insert_unit
	import sti_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int KEY_BITS    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [IN_KEY_W-1:0] new_key,
	output logic                done,
	output logic [FIELD_W-1:0]  insert_position,
	output logic [FIELD_W-1:0]  entry_total,
	output logic                table_full,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
	localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_PUT   = 3'd4;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hi_q;
	logic [CNT_W-1:0]    mid_q;
	logic [CNT_W-1:0]    sh_q;
	logic [KEY_BITS-1:0] key_q;
	logic                mode_q;
	logic                done_q;
	logic                full_q;
	logic [CNT_W-1:0]    position_q;
	logic [CNT_W-1:0]    total_q;

	logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
	logic [KEY_BITS-1:0] rdata_q;

	logic [KEY_BITS-1:0] key_in;
	logic [CNT_W-1:0]    mid;
	logic                accept;
	logic                key_lt;
	logic                rd_en;
	logic [IDX_W-1:0]    raddr;
	logic                wr_en;
	logic [IDX_W-1:0]    waddr;
	logic [KEY_BITS-1:0] wdata;

	// The key port is cut or zero-extended to KEY_BITS; the count outputs likewise to FIELD_W.
	generate
		if (KEY_BITS <= IN_KEY_W) begin : g_key_trunc
			assign key_in = new_key[KEY_BITS-1:0];
		end else begin : g_key_ext
			assign key_in = {{(KEY_BITS - IN_KEY_W){1'b0}}, new_key};
		end
		if (CNT_W >= FIELD_W) begin : g_out_trunc
			assign insert_position = position_q[FIELD_W-1:0];
			assign entry_total     = total_q[FIELD_W-1:0];
		end else begin : g_out_ext
			assign insert_position = {{(FIELD_W - CNT_W){1'b0}}, position_q};
			assign entry_total     = {{(FIELD_W - CNT_W){1'b0}}, total_q};
		end
	endgenerate

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign table_full = full_q;
	assign cfg_ready  = 1'b1;
	assign mid        = lo_q + ((hi_q - lo_q) >> 1);

	sti_key_cmp #(
		.KEY_BITS (KEY_BITS)
	) u_cmp (
		.key_a       (key_q),
		.key_b       (rdata_q),
		.signed_mode (mode_q),
		.a_less      (key_lt)
	);

	// Memory port control.
	always_comb begin
		rd_en = 1'b0;
		raddr = '0;
		wr_en = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		unique case (state_q)
			ST_RD: begin
				rd_en = 1'b1;
				if (lo_q < hi_q) begin
					raddr = mid[IDX_W-1:0];
				end else begin
					raddr = IDX_W'(count_q - ONE);
				end
			end
			ST_SHIFT: begin
				wr_en = 1'b1;
				waddr = sh_q[IDX_W-1:0];
				rd_en = 1'b1;
				raddr = IDX_W'(sh_q - CNT_W'(2));
			end
			ST_PUT: begin
				wr_en = 1'b1;
				waddr = lo_q[IDX_W-1:0];
				wdata = key_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= key_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (count_q == DEPTH_CNT) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (lo_q < hi_q) begin
						state_q <= ST_CMP;
					end else if (count_q > lo_q) begin
						state_q <= ST_SHIFT;
					end else begin
						state_q <= ST_PUT;
					end
				end
				ST_CMP: begin
					state_q <= ST_RD;
				end
				ST_SHIFT: begin
					if (sh_q - ONE <= lo_q) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					count_q <= count_q + ONE;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search bounds, shift pointer and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_q      <= key_in;
					lo_q       <= '0;
					hi_q       <= count_q;
					position_q <= count_q;
					total_q    <= count_q;
					full_q     <= (count_q == DEPTH_CNT);
				end
			end
			ST_RD: begin
				mid_q <= mid;
				sh_q  <= count_q;
			end
			ST_CMP: begin
				// Equal keys move the search right, so the new key follows them.
				if (key_lt) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + ONE;
				end
			end
			ST_SHIFT: begin
				sh_q <= sh_q - ONE;
			end
			ST_PUT: begin
				position_q <= lo_q;
				total_q    <= count_q + ONE;
				full_q     <= 1'b0;
			end
			default: begin
				sh_q <= sh_q;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !full_q) |-> (position_q < total_q))
		else $error("inserted position not below the new count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT) |-> ((sh_q > lo_q) && (sh_q <= count_q)))
		else $error("shift pointer outside the moved range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ((mid_q >= lo_q) && (mid_q < hi_q)))
		else $error("search midpoint outside its bounds");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (count_q == DEPTH_CNT)) |=> (done_q && full_q))
		else $error("full table did not report a dropped key");

endmodule

FILE: tb/sv/sorted_table_insert_unit_tb.sv
// Self-checking testbench for the sorted table insert unit.
module sorted_table_insert_unit_tb
	import sti_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;

	typedef struct packed {
		logic [FIELD_W-1:0] position;
		logic [FIELD_W-1:0] total;
		logic               full;
	} insert_result_t;

	class insert_checker;
		logic [IN_KEY_W-1:0] keys [TABLE_DEPTH];
		int                  count;
		logic                signed_mode;
		insert_result_t      expected_inserts [$];
		int                  errors;

		function new();
			foreach (keys[i]) keys[i] = '0;
			count = 0;
			signed_mode = MODE_UNSIGNED;
			errors = 0;
		endfunction

		function void set_mode(logic mode);
			signed_mode = mode;
		endfunction

		function bit key_below(logic [IN_KEY_W-1:0] a, logic [IN_KEY_W-1:0] b);
			if (signed_mode == MODE_SIGNED) begin
				return $signed(a) < $signed(b);
			end
			return a < b;
		endfunction

		// Upper-bound binary search, so equal keys keep their arrival order.
		function void note_key(logic [IN_KEY_W-1:0] key);
			insert_result_t r;
			int lo;
			int hi;
			int mid;
			if (count >= TABLE_DEPTH) begin
				r.position = count[FIELD_W-1:0];
				r.total = count[FIELD_W-1:0];
				r.full = 1'b1;
			end else begin
				lo = 0;
				hi = count;
				while (lo < hi) begin
					mid = lo + ((hi - lo) >> 1);
					if (key_below(key, keys[mid])) begin
						hi = mid;
					end else begin
						lo = mid + 1;
					end
				end
				for (int i = count; i > lo; i--) keys[i] = keys[i-1];
				keys[lo] = key;
				count++;
				r.position = lo[FIELD_W-1:0];
				r.total = count[FIELD_W-1:0];
				r.full = 1'b0;
			end
			expected_inserts.push_back(r);
		endfunction

		function void check_result(logic [FIELD_W-1:0] position, logic [FIELD_W-1:0] total,
				logic full);
			insert_result_t e;
			if (expected_inserts.size() == 0) begin
				$display("%0t: unexpected result position %0d total %0d full %0d",
					$time, position, total, full);
				errors++;
				return;
			end
			e = expected_inserts.pop_front();
			if (position !== e.position) begin
				$display("%0t: insert_position expected %0d actual %0d", $time, e.position,
					position);
				errors++;
			end
			if (total !== e.total) begin
				$display("%0t: entry_total expected %0d actual %0d", $time, e.total, total);
				errors++;
			end
			if (full !== e.full) begin
				$display("%0t: table_full expected %0d actual %0d", $time, e.full, full);
				errors++;
			end
		endfunction

		function int pending();
			return expected_inserts.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [IN_KEY_W-1:0] new_key = '0;
	logic                done;
	logic [FIELD_W-1:0]  insert_position;
	logic [FIELD_W-1:0]  entry_total;
	logic                table_full;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_data = 1'b0;

	insert_checker       board = new();
	int                  idle_pct = 0;
	int                  quiet_cycles = 0;
	logic [IN_KEY_W-1:0] key_pool [$];

	sorted_table_insert_unit #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS(IN_KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.new_key(new_key),
		.done(done),
		.insert_position(insert_position),
		.entry_total(entry_total),
		.table_full(table_full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Everything is sampled here before any update of this edge lands, so an item
	// is always noted before a result that it causes is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.set_mode(cfg_data);
			if (start && !busy) board.note_key(new_key);
			if (done) board.check_result(insert_position, entry_total, table_full);
			if ((cfg_valid && cfg_ready) || (start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no activity for %0d cycles", $time, QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_key(input logic [IN_KEY_W-1:0] key);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		new_key <= key;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mix of repeats, extremes, tiny values and full-range values so that
	// duplicates and sign boundaries show up often.
	function automatic logic [IN_KEY_W-1:0] pick_key();
		logic [IN_KEY_W-1:0] k;
		int sel;
		sel = $urandom_range(9);
		if (sel < 4 && key_pool.size() != 0) begin
			k = key_pool[$urandom_range(key_pool.size() - 1)];
		end else if (sel < 6) begin
			case ($urandom_range(3))
				0: k = 32'h0000_0000;
				1: k = 32'hFFFF_FFFF;
				2: k = 32'h8000_0000;
				default: k = 32'h7FFF_FFFF;
			endcase
		end else if (sel == 6) begin
			k = $urandom_range(15);
		end else begin
			k = $urandom;
		end
		key_pool.push_back(k);
		if (key_pool.size() > 32) void'(key_pool.pop_front());
		return k;
	endfunction

	initial begin
		int phase_items;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Unsigned ordering, starting from the empty table, with duplicates.
		write_mode(MODE_UNSIGNED);
		send_key(32'h0000_0005);
		send_key(32'h0000_0000);
		send_key(32'hFFFF_FFFF);
		send_key(32'h8000_0000);
		send_key(32'h7FFF_FFFF);
		send_key(32'h0000_0005);
		send_key(32'h0000_0005);
		send_key(32'h0000_0000);
		send_key(32'hFFFF_FFFF);
		send_key(32'h0000_0003);
		send_key(32'h1234_5678);

		// Switch to signed while entries are held; the table is not re-sorted.
		write_mode(MODE_SIGNED);
		send_key(32'h8000_0000);
		send_key(32'hFFFF_FFFF);
		send_key(32'h0000_0000);
		send_key(32'h0000_0005);
		send_key(32'h7FFF_FFFF);
		send_key(32'h8000_0001);
		send_key(32'hFFFF_FFFE);

		// Short phases first so that mode changes fall while the table is filling;
		// the long ones then exercise the full table.
		for (int p = 0; p < 8; p++) begin
			write_mode((p % 2 == 0) ? MODE_UNSIGNED : MODE_SIGNED);
			case (p % 4)
				0: idle_pct = 0;
				1: idle_pct = 81;
				2: idle_pct = 32;
				default: idle_pct = 0;
			endcase
			phase_items = (p < 4) ? 12 : 170;
			for (int n = 0; n < phase_items; n++) send_key(pick_key());
		end

		drain();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: sorted_table_insert_unit.f
rtl/sti_pkg.sv
rtl/sti_key_cmp.sv
rtl/sorted_table_insert_unit.sv
tb/sv/sorted_table_insert_unit_tb.sv
